FILE: hdl/phong_pkg.sv
// ----------------------------------------------------------------------------
// phong_pkg
// Shared widths, vector types and register codes of the Phong pixel shader.
// ----------------------------------------------------------------------------
package phong_pkg;

  // Raw vector components entering a normalizer (signed, magnitude below 2^18)
  localparam int VEC_W   = 19;
  localparam int MAG_W   = VEC_W - 1;
  // Sum of three squares and the scaled radicand s * 2^24
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int RAD_SH  = 24;
  localparam int RAD_W   = SUM_W + RAD_SH;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  // Divider: dividend is |v| * 2^26 + q / 2, quotient never exceeds 2^14
  localparam int DIV_SH  = 26;
  localparam int DIVD_W  = MAG_W + DIV_SH + 1;
  localparam int QUO_W   = 15;
  // Q2.14 unit components
  localparam int UNIT_W  = 16;
  localparam int FRAC_W  = 14;
  // Normalizer depth: magnitude, square, sum, root steps, dividend, divide steps, output
  localparam int NORM_LAT = 3 + ROOT_W + 1 + QUO_W + 1;

  // Dot products and color path
  localparam int PROD_W  = 2 * UNIT_W;
  localparam int DSUM_W  = PROD_W + 2;
  localparam int D_W     = 19;
  localparam int DN_W    = D_W + UNIT_W;
  localparam int RT_W    = DN_W + 2;
  localparam int CPROD_W = 32;
  localparam int TERM_W  = (D_W - 1) + CPROD_W - FRAC_W;
  localparam int ACC_W   = TERM_W + 2;
  localparam int SAT_W   = 31;
  localparam int ONE_Q30 = 1 << 30;
  localparam int SCL_W   = SAT_W + 8;
  localparam int CHAN_W  = 16;
  localparam int COLOR_W = 3 * CHAN_W;

  // Pipeline depth from accepted start to result strobe
  localparam int TOP_LAT = 2 + NORM_LAT + 4 + NORM_LAT + 5;

  // Configuration
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;

  typedef logic signed [VEC_W-1:0]  comp_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef enum logic [2:0] {
    REG_LIGHT_POS,
    REG_CAM_DIST,
    REG_LIGHT_AMB,
    REG_MAT_AMB,
    REG_LIGHT_DIF,
    REG_MAT_DIF,
    REG_LIGHT_SPC,
    REG_MAT_SPC
  } reg_idx_t;

endpackage

FILE: hdl/phong_norm.sv
// ----------------------------------------------------------------------------
// phong_norm
// Pipelined vector normalizer: one 3-component vector per clock in, its
// Q2.14 unit vector out after a fixed latency (zero vector stays zero).
// ----------------------------------------------------------------------------
module phong_norm (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  phong_pkg::comp_t  vec_in  [3],
  output logic              out_valid,
  output phong_pkg::unit_t  vec_out [3]
);

  // Stage 1: magnitude and sign
  logic                         vld1;
  logic [phong_pkg::MAG_W-1:0]  mag1 [3];
  logic                         neg1 [3];
  // Stage 2: squares
  logic                         vld2;
  logic [phong_pkg::SQ_W-1:0]   sqr2 [3];
  logic [phong_pkg::MAG_W-1:0]  mag2 [3];
  logic                         neg2 [3];

  // Root pipeline, index 0 is the sum stage
  logic                         sq_vld  [phong_pkg::ROOT_W+1];
  logic [phong_pkg::SUM_W-1:0]  sq_s    [phong_pkg::ROOT_W+1];
  logic [phong_pkg::ROOT_W-1:0] sq_root [phong_pkg::ROOT_W+1];
  logic [phong_pkg::REM_W-1:0]  sq_rem  [phong_pkg::ROOT_W+1];
  logic [phong_pkg::MAG_W-1:0]  sq_mag  [phong_pkg::ROOT_W+1][3];
  logic                         sq_neg  [phong_pkg::ROOT_W+1][3];

  // Divide pipeline, index 0 is the dividend stage
  logic                         dv_vld  [phong_pkg::QUO_W+1];
  logic                         dv_zero [phong_pkg::QUO_W+1];
  logic [phong_pkg::ROOT_W-1:0] dv_q    [phong_pkg::QUO_W+1];
  logic [phong_pkg::DIVD_W-1:0] dv_rem  [phong_pkg::QUO_W+1][3];
  logic [phong_pkg::QUO_W-1:0]  dv_quo  [phong_pkg::QUO_W+1][3];
  logic                         dv_neg  [phong_pkg::QUO_W+1][3];

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      sq_vld[0] <= 1'b0;
    end else begin
      vld1 <= in_valid;
      vld2 <= vld1;
      sq_vld[0] <= vld2;
    end
  end

  // Take magnitudes, square, sum
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag1[k] <= phong_pkg::MAG_W'((vec_in[k] < 0) ? -vec_in[k] : vec_in[k]);
      neg1[k] <= vec_in[k] < 0;
      sqr2[k] <= phong_pkg::SQ_W'(mag1[k]) * phong_pkg::SQ_W'(mag1[k]);
      mag2[k] <= mag1[k];
      neg2[k] <= neg1[k];
      sq_mag[0][k] <= mag2[k];
      sq_neg[0][k] <= neg2[k];
    end
    sq_s[0] <= phong_pkg::SUM_W'(sqr2[0]) + phong_pkg::SUM_W'(sqr2[1])
             + phong_pkg::SUM_W'(sqr2[2]);
    sq_root[0] <= '0;
    sq_rem[0]  <= '0;
  end

  // Square root, one result bit per stage
  for (genvar i = 0; i < phong_pkg::ROOT_W; i++) begin : g_root
    localparam int J = phong_pkg::ROOT_W - 1 - i;
    logic [phong_pkg::RAD_W-1:0] rad;
    logic [phong_pkg::REM_W-1:0] rem_sh;
    logic [phong_pkg::REM_W-1:0] trial;

    assign rad    = {sq_s[i], {phong_pkg::RAD_SH{1'b0}}};
    assign rem_sh = {sq_rem[i][phong_pkg::REM_W-3:0], rad[2*J+1 -: 2]};
    assign trial  = {1'b0, sq_root[i], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[i+1] <= 1'b0;
      end else begin
        sq_vld[i+1] <= sq_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rem_sh >= trial) begin
        sq_rem[i+1]  <= rem_sh - trial;
        sq_root[i+1] <= {sq_root[i][phong_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem[i+1]  <= rem_sh;
        sq_root[i+1] <= {sq_root[i][phong_pkg::ROOT_W-2:0], 1'b0};
      end
      sq_s[i+1]   <= sq_s[i];
      sq_mag[i+1] <= sq_mag[i];
      sq_neg[i+1] <= sq_neg[i];
    end
  end

  // Form rounded dividends from the length
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= sq_vld[phong_pkg::ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    dv_q[0]    <= sq_root[phong_pkg::ROOT_W];
    dv_zero[0] <= sq_root[phong_pkg::ROOT_W] == '0;
    for (int k = 0; k < 3; k++) begin
      dv_rem[0][k] <= (phong_pkg::DIVD_W'(sq_mag[phong_pkg::ROOT_W][k]) << phong_pkg::DIV_SH)
                    + phong_pkg::DIVD_W'(sq_root[phong_pkg::ROOT_W] >> 1);
      dv_quo[0][k] <= '0;
      dv_neg[0][k] <= sq_neg[phong_pkg::ROOT_W][k];
    end
  end

  // Restoring divide, one quotient bit per stage
  for (genvar i = 0; i < phong_pkg::QUO_W; i++) begin : g_div
    localparam int B = phong_pkg::QUO_W - 1 - i;
    logic [phong_pkg::DIVD_W-1:0] dsr;

    assign dsr = phong_pkg::DIVD_W'(dv_q[i]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[i+1] <= 1'b0;
      end else begin
        dv_vld[i+1] <= dv_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_rem[i][k] >= dsr) begin
          dv_rem[i+1][k] <= dv_rem[i][k] - dsr;
          dv_quo[i+1][k] <= {dv_quo[i][k][phong_pkg::QUO_W-2:0], 1'b1};
        end else begin
          dv_rem[i+1][k] <= dv_rem[i][k];
          dv_quo[i+1][k] <= {dv_quo[i][k][phong_pkg::QUO_W-2:0], 1'b0};
        end
      end
      dv_q[i+1]    <= dv_q[i];
      dv_zero[i+1] <= dv_zero[i];
      dv_neg[i+1]  <= dv_neg[i];
    end
  end

  // Apply sign, force zero length to the zero vector
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_vld[phong_pkg::QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (dv_zero[phong_pkg::QUO_W]) begin
        vec_out[k] <= '0;
      end else if (dv_neg[phong_pkg::QUO_W][k]) begin
        vec_out[k] <= -phong_pkg::unit_t'(dv_quo[phong_pkg::QUO_W][k]);
      end else begin
        vec_out[k] <= phong_pkg::unit_t'(dv_quo[phong_pkg::QUO_W][k]);
      end
    end
  end

  // Checks
  a_lat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, phong_pkg::NORM_LAT))
    else $error("normalizer output without matching input");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(vec_in[0] == 0 && vec_in[1] == 0 && vec_in[2] == 0,
                       phong_pkg::NORM_LAT)
    |-> vec_out[0] == 0 && vec_out[1] == 0 && vec_out[2] == 0)
    else $error("zero vector did not normalize to zero");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vec_out[0] <= 16384 && vec_out[0] >= -16384 &&
                  vec_out[1] <= 16384 && vec_out[1] >= -16384 &&
                  vec_out[2] <= 16384 && vec_out[2] >= -16384)
    else $error("normalized component beyond one");

endmodule

FILE: hdl/phong_pixel_shader.sv
// ----------------------------------------------------------------------------
// phong_pixel_shader
// Fixed-point Phong shading of one fragment per clock: ambient, diffuse and
// specular (exponent 1) terms, saturated and rounded to 8-bit RGB.
// ----------------------------------------------------------------------------
// A fragment is taken on any clock where start is high and busy is low; busy
// is high only during reset, so one fragment per clock is sustained. Its color
// appears on red/green/blue with done high for one cycle, in order. The depth
// comes from two chained vector normalizers (light vector, then reflection
// vector), each a 51-stage pipe made of a 31-step square root and a 15-step
// divide; the view vector is normalized alongside the light vector. Registers
// sit on the APB port at byte address 8*i with 64-bit data; write them only
// while no fragment is in flight.
module phong_pixel_shader (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            point_x,
  input  logic signed [15:0]            point_y,
  input  logic signed [15:0]            point_z,
  input  logic signed [15:0]            normal_x,
  input  logic signed [15:0]            normal_y,
  input  logic signed [15:0]            normal_z,
  output logic                          done,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [phong_pkg::ADDR_W-1:0]  paddr,
  input  logic [phong_pkg::DATA_W-1:0]  pwdata,
  output logic [phong_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration registers
  logic [phong_pkg::COLOR_W-1:0] light_pos;
  logic [phong_pkg::CHAN_W-1:0]  camera_distance;
  logic [phong_pkg::COLOR_W-1:0] light_ambient_rgb;
  logic [phong_pkg::COLOR_W-1:0] material_ambient_rgb;
  logic [phong_pkg::COLOR_W-1:0] light_diffuse_rgb;
  logic [phong_pkg::COLOR_W-1:0] material_diffuse_rgb;
  logic [phong_pkg::COLOR_W-1:0] light_specular_rgb;
  logic [phong_pkg::COLOR_W-1:0] material_specular_rgb;
  phong_pkg::reg_idx_t           reg_idx;

  // Color products per channel
  logic [phong_pkg::CPROD_W-1:0] prod_amb [3];
  logic [phong_pkg::CPROD_W-1:0] prod_dif [3];
  logic [phong_pkg::CPROD_W-1:0] prod_spc [3];

  // Front stages
  logic             accept;
  logic             vld1, vld2;
  phong_pkg::unit_t pnt1 [3];
  phong_pkg::unit_t nrm1 [3];
  phong_pkg::unit_t nrm2 [3];
  phong_pkg::comp_t lvec2 [3];
  phong_pkg::comp_t vvec2 [3];

  // Normalizer results
  logic             l_valid, v_valid, r_valid;
  phong_pkg::unit_t lunit [3];
  phong_pkg::unit_t vunit [3];
  phong_pkg::unit_t runit [3];

  // Delay lines
  phong_pkg::unit_t                nrm_line [phong_pkg::NORM_LAT][3];
  phong_pkg::unit_t                vw_line  [phong_pkg::NORM_LAT+4][3];
  logic signed [phong_pkg::D_W-1:0] d_line  [phong_pkg::NORM_LAT];

  // Reflection stages
  logic                                vld_a1, vld_a2, vld_a3, vld_a4;
  logic signed [phong_pkg::PROD_W-1:0] ln_prod [3];
  phong_pkg::unit_t                    l_b [3], n_b [3], l_c [3], n_c [3], l_d [3];
  logic signed [phong_pkg::DSUM_W-1:0] ln_sum;
  logic signed [phong_pkg::D_W-1:0]    d_c, d_d, d_e;
  logic signed [phong_pkg::DN_W-1:0]   dn_d [3];
  phong_pkg::comp_t                    rvec_e [3];

  // Shading stages
  logic                                vld_b1, vld_b2, vld_b3, vld_b4;
  logic signed [phong_pkg::PROD_W-1:0] rv_prod [3];
  logic signed [phong_pkg::DSUM_W-1:0] rv_sum;
  logic signed [phong_pkg::D_W-1:0]    d_f, d_g, sp_g;
  logic [phong_pkg::TERM_W-1:0]        term_d [3];
  logic [phong_pkg::TERM_W-1:0]        term_s [3];
  logic [phong_pkg::CPROD_W-1:0]       term_a [3];
  logic [phong_pkg::SAT_W-1:0]         acc [3];
  logic [phong_pkg::SCL_W-1:0]         scaled [3];

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = phong_pkg::reg_idx_t'(paddr[phong_pkg::ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      light_pos             <= '0;
      camera_distance       <= '0;
      light_ambient_rgb     <= '0;
      material_ambient_rgb  <= '0;
      light_diffuse_rgb     <= '0;
      material_diffuse_rgb  <= '0;
      light_specular_rgb    <= '0;
      material_specular_rgb <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        phong_pkg::REG_LIGHT_POS: light_pos             <= pwdata[phong_pkg::COLOR_W-1:0];
        phong_pkg::REG_CAM_DIST:  camera_distance       <= pwdata[phong_pkg::CHAN_W-1:0];
        phong_pkg::REG_LIGHT_AMB: light_ambient_rgb     <= pwdata[phong_pkg::COLOR_W-1:0];
        phong_pkg::REG_MAT_AMB:   material_ambient_rgb  <= pwdata[phong_pkg::COLOR_W-1:0];
        phong_pkg::REG_LIGHT_DIF: light_diffuse_rgb     <= pwdata[phong_pkg::COLOR_W-1:0];
        phong_pkg::REG_MAT_DIF:   material_diffuse_rgb  <= pwdata[phong_pkg::COLOR_W-1:0];
        phong_pkg::REG_LIGHT_SPC: light_specular_rgb    <= pwdata[phong_pkg::COLOR_W-1:0];
        phong_pkg::REG_MAT_SPC:   material_specular_rgb <= pwdata[phong_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      phong_pkg::REG_LIGHT_POS: prdata = phong_pkg::DATA_W'(light_pos);
      phong_pkg::REG_CAM_DIST:  prdata = phong_pkg::DATA_W'(camera_distance);
      phong_pkg::REG_LIGHT_AMB: prdata = phong_pkg::DATA_W'(light_ambient_rgb);
      phong_pkg::REG_MAT_AMB:   prdata = phong_pkg::DATA_W'(material_ambient_rgb);
      phong_pkg::REG_LIGHT_DIF: prdata = phong_pkg::DATA_W'(light_diffuse_rgb);
      phong_pkg::REG_MAT_DIF:   prdata = phong_pkg::DATA_W'(material_diffuse_rgb);
      phong_pkg::REG_LIGHT_SPC: prdata = phong_pkg::DATA_W'(light_specular_rgb);
      phong_pkg::REG_MAT_SPC:   prdata = phong_pkg::DATA_W'(material_specular_rgb);
      default:                  prdata = '0;
    endcase
  end

  // Precompute light times material per channel
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      prod_amb[c] <= phong_pkg::CPROD_W'(light_ambient_rgb[16*c +: 16])
                   * phong_pkg::CPROD_W'(material_ambient_rgb[16*c +: 16]);
      prod_dif[c] <= phong_pkg::CPROD_W'(light_diffuse_rgb[16*c +: 16])
                   * phong_pkg::CPROD_W'(material_diffuse_rgb[16*c +: 16]);
      prod_spc[c] <= phong_pkg::CPROD_W'(light_specular_rgb[16*c +: 16])
                   * phong_pkg::CPROD_W'(material_specular_rgb[16*c +: 16]);
    end
  end

  // Input transaction
  assign busy   = rst;
  assign accept = start && !busy;

  // Valid chain outside the normalizers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1   <= 1'b0;
      vld2   <= 1'b0;
      vld_a1 <= 1'b0;
      vld_a2 <= 1'b0;
      vld_a3 <= 1'b0;
      vld_a4 <= 1'b0;
      vld_b1 <= 1'b0;
      vld_b2 <= 1'b0;
      vld_b3 <= 1'b0;
      vld_b4 <= 1'b0;
      done   <= 1'b0;
    end else begin
      vld1   <= accept;
      vld2   <= vld1;
      vld_a1 <= l_valid;
      vld_a2 <= vld_a1;
      vld_a3 <= vld_a2;
      vld_a4 <= vld_a3;
      vld_b1 <= r_valid;
      vld_b2 <= vld_b1;
      vld_b3 <= vld_b2;
      vld_b4 <= vld_b3;
      done   <= vld_b4;
    end
  end

  // Capture fragment, form light and view vectors
  always_ff @(posedge clk) begin
    pnt1[0] <= point_x;
    pnt1[1] <= point_y;
    pnt1[2] <= point_z;
    nrm1[0] <= normal_x;
    nrm1[1] <= normal_y;
    nrm1[2] <= normal_z;
    for (int k = 0; k < 3; k++) begin
      lvec2[k] <= phong_pkg::comp_t'($signed(light_pos[16*k +: 16]))
                - phong_pkg::comp_t'(pnt1[k]);
      nrm2[k]  <= nrm1[k];
    end
    vvec2[0] <= -phong_pkg::comp_t'(pnt1[0]);
    vvec2[1] <= -phong_pkg::comp_t'(pnt1[1]);
    vvec2[2] <= -phong_pkg::comp_t'($signed({1'b0, camera_distance}))
              - phong_pkg::comp_t'(pnt1[2]);
  end

  phong_norm u_norm_l (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld2),
    .vec_in    (lvec2),
    .out_valid (l_valid),
    .vec_out   (lunit)
  );

  phong_norm u_norm_v (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld2),
    .vec_in    (vvec2),
    .out_valid (v_valid),
    .vec_out   (vunit)
  );

  // Hold normal, view vector and N.L alongside the normalizers
  always_ff @(posedge clk) begin
    nrm_line[0] <= nrm2;
    for (int i = 1; i < phong_pkg::NORM_LAT; i++) begin
      nrm_line[i] <= nrm_line[i-1];
    end
    vw_line[0] <= vunit;
    for (int i = 1; i < phong_pkg::NORM_LAT + 4; i++) begin
      vw_line[i] <= vw_line[i-1];
    end
    d_line[0] <= d_e;
    for (int i = 1; i < phong_pkg::NORM_LAT; i++) begin
      d_line[i] <= d_line[i-1];
    end
  end

  // N.L products, then rounded sum
  assign ln_sum = phong_pkg::DSUM_W'(ln_prod[0]) + phong_pkg::DSUM_W'(ln_prod[1])
                + phong_pkg::DSUM_W'(ln_prod[2])
                + phong_pkg::DSUM_W'(1 << (phong_pkg::FRAC_W - 1));

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ln_prod[k] <= lunit[k] * nrm_line[phong_pkg::NORM_LAT-1][k];
      l_b[k]     <= lunit[k];
      n_b[k]     <= nrm_line[phong_pkg::NORM_LAT-1][k];
      l_c[k]     <= l_b[k];
      n_c[k]     <= n_b[k];
      l_d[k]     <= l_c[k];
    end
    d_c <= phong_pkg::D_W'(ln_sum >>> phong_pkg::FRAC_W);
  end

  // Reflection vector R = 2(N.L)N - L before normalizing
  always_ff @(posedge clk) begin : p_refl
    logic signed [phong_pkg::RT_W-1:0] rt;
    for (int k = 0; k < 3; k++) begin
      dn_d[k] <= d_c * n_c[k];
    end
    d_d <= d_c;
    for (int k = 0; k < 3; k++) begin
      rt = (phong_pkg::RT_W'(dn_d[k]) <<< 1)
         + phong_pkg::RT_W'(1 << (phong_pkg::FRAC_W - 1));
      rvec_e[k] <= phong_pkg::VEC_W'((rt >>> phong_pkg::FRAC_W) - phong_pkg::RT_W'(l_d[k]));
    end
    d_e <= d_d;
  end

  phong_norm u_norm_r (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_a4),
    .vec_in    (rvec_e),
    .out_valid (r_valid),
    .vec_out   (runit)
  );

  // R.V products, then rounded sum
  assign rv_sum = phong_pkg::DSUM_W'(rv_prod[0]) + phong_pkg::DSUM_W'(rv_prod[1])
                + phong_pkg::DSUM_W'(rv_prod[2])
                + phong_pkg::DSUM_W'(1 << (phong_pkg::FRAC_W - 1));

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      rv_prod[k] <= runit[k] * vw_line[phong_pkg::NORM_LAT+3][k];
    end
    d_f  <= d_line[phong_pkg::NORM_LAT-1];
    sp_g <= phong_pkg::D_W'(rv_sum >>> phong_pkg::FRAC_W);
    d_g  <= d_f;
  end

  // Lit terms, drop the ones facing away
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      term_a[c] <= prod_amb[c];
      if (d_g > 0) begin
        term_d[c] <= phong_pkg::TERM_W'(
          ((phong_pkg::TERM_W + phong_pkg::FRAC_W)'(d_g[phong_pkg::D_W-2:0])
           * (phong_pkg::TERM_W + phong_pkg::FRAC_W)'(prod_dif[c])) >> phong_pkg::FRAC_W);
      end else begin
        term_d[c] <= '0;
      end
      if (sp_g > 0) begin
        term_s[c] <= phong_pkg::TERM_W'(
          ((phong_pkg::TERM_W + phong_pkg::FRAC_W)'(sp_g[phong_pkg::D_W-2:0])
           * (phong_pkg::TERM_W + phong_pkg::FRAC_W)'(prod_spc[c])) >> phong_pkg::FRAC_W);
      end else begin
        term_s[c] <= '0;
      end
    end
  end

  // Sum and saturate at one
  always_ff @(posedge clk) begin : p_acc
    logic [phong_pkg::ACC_W-1:0] total;
    for (int c = 0; c < 3; c++) begin
      total = phong_pkg::ACC_W'(term_a[c]) + phong_pkg::ACC_W'(term_d[c])
            + phong_pkg::ACC_W'(term_s[c]);
      if (total > phong_pkg::ACC_W'(phong_pkg::ONE_Q30)) begin
        acc[c] <= phong_pkg::SAT_W'(phong_pkg::ONE_Q30);
      end else begin
        acc[c] <= phong_pkg::SAT_W'(total);
      end
    end
  end

  // Scale by 255 and round to a byte
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      scaled[c] = (phong_pkg::SCL_W'(acc[c]) << 8) - phong_pkg::SCL_W'(acc[c])
                + phong_pkg::SCL_W'(phong_pkg::ONE_Q30 / 2);
    end
  end

  always_ff @(posedge clk) begin
    red   <= scaled[0][37:30];
    green <= scaled[1][37:30];
    blue  <= scaled[2][37:30];
  end

  // Checks
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, phong_pkg::TOP_LAT))
    else $error("result strobe without matching fragment");

  a_side: assert property (@(posedge clk) disable iff (rst)
    vld_b3 && $past(d_g <= 0) |-> term_d[0] == 0 && term_d[1] == 0 && term_d[2] == 0)
    else $error("diffuse term on a back-facing light");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    vld_b4 |-> acc[0] <= phong_pkg::ONE_Q30 && acc[1] <= phong_pkg::ONE_Q30 &&
               acc[2] <= phong_pkg::ONE_Q30)
    else $error("channel sum above one after saturation");

  a_align: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> v_valid == 1'b0 || $past(v_valid, phong_pkg::NORM_LAT + 4))
    else $error("view vector out of step with reflection vector");

endmodule

FILE: tb/sv/phong_shade_checker.sv
// ----------------------------------------------------------------------------
// phong_shade_checker
// Watches the fragment, color and APB channels of the Phong pixel shader,
// predicts the shaded color of every accepted fragment from its own copy of
// the registers and compares each color strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module phong_shade_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [15:0]            point_x,
  input  logic signed [15:0]            point_y,
  input  logic signed [15:0]            point_z,
  input  logic signed [15:0]            normal_x,
  input  logic signed [15:0]            normal_y,
  input  logic signed [15:0]            normal_z,
  input  logic                          done,
  input  logic [7:0]                    red,
  input  logic [7:0]                    green,
  input  logic [7:0]                    blue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [phong_pkg::ADDR_W-1:0]  paddr,
  input  logic [phong_pkg::DATA_W-1:0]  pwdata,
  output int                            fail_count,
  output int                            colors_pending
);

  typedef longint vec3_t [3];

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Shadow copies of the shader registers
  logic [47:0]      light_pos;
  logic [15:0]      cam_dist;
  logic [phong_pkg::COLOR_W-1:0] color_regs [6];

  rgb_t color_fifo [$];

  function automatic longint sext16(logic [15:0] x);
    return longint'(signed'(x));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale a vector to Q2.14 unit length; a zero vector stays zero
  function automatic vec3_t unit_vec(vec3_t v);
    longint unsigned s, q, m, r;
    vec3_t o;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      m = (v[k] < 0) ? -v[k] : v[k];
      s = s + m * m;
    end
    q = int_sqrt(s << 24);
    for (int k = 0; k < 3; k++) begin
      if (q == 0) begin
        o[k] = 0;
      end else begin
        m = (v[k] < 0) ? -v[k] : v[k];
        r = ((m << 26) + q / 2) / q;
        o[k] = (v[k] < 0) ? -longint'(r) : longint'(r);
      end
    end
    return o;
  endfunction

  function automatic longint dot_q14(vec3_t a, vec3_t b);
    longint sum;
    sum = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    return (sum + 8192) >>> 14;
  endfunction

  function automatic rgb_t shade(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                                 logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    vec3_t p, n, lv, l, vv, v, rv, rr;
    longint nl, rv_dot;
    longint unsigned acc, cp;
    logic [7:0] ch [3];
    rgb_t res;
    p[0] = sext16(px); p[1] = sext16(py); p[2] = sext16(pz);
    n[0] = sext16(nx); n[1] = sext16(ny); n[2] = sext16(nz);
    for (int k = 0; k < 3; k++) lv[k] = sext16(light_pos[16*k +: 16]) - p[k];
    l  = unit_vec(lv);
    nl = dot_q14(l, n);
    vv[0] = -p[0];
    vv[1] = -p[1];
    vv[2] = -longint'(cam_dist) - p[2];
    v = unit_vec(vv);
    for (int k = 0; k < 3; k++) rv[k] = ((2 * nl * n[k] + 8192) >>> 14) - l[k];
    rr     = unit_vec(rv);
    rv_dot = dot_q14(rr, v);
    for (int c = 0; c < 3; c++) begin
      acc = longint'(color_regs[0][16*c +: 16]) * longint'(color_regs[1][16*c +: 16]);
      if (nl > 0) begin
        cp  = longint'(color_regs[2][16*c +: 16]) * longint'(color_regs[3][16*c +: 16]);
        acc = acc + ((longint'(nl) * cp) >> 14);
      end
      if (rv_dot > 0) begin
        cp  = longint'(color_regs[4][16*c +: 16]) * longint'(color_regs[5][16*c +: 16]);
        acc = acc + ((longint'(rv_dot) * cp) >> 14);
      end
      if (acc > 64'd1073741824) acc = 64'd1073741824;
      ch[c] = 8'((255 * acc + 64'd536870912) >> 30);
    end
    res.r = ch[0];
    res.g = ch[1];
    res.b = ch[2];
    return res;
  endfunction

  // Track registers, queue predictions and compare color strobes
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      light_pos  <= '0;
      cam_dist   <= '0;
      for (int i = 0; i < 6; i++) color_regs[i] <= '0;
      fail_count     <= 0;
      colors_pending <= 0;
      color_fifo.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (phong_pkg::reg_idx_t'(paddr[phong_pkg::ADDR_W-1:3]))
          phong_pkg::REG_LIGHT_POS: light_pos     <= pwdata[47:0];
          phong_pkg::REG_CAM_DIST:  cam_dist      <= pwdata[15:0];
          phong_pkg::REG_LIGHT_AMB: color_regs[0] <= pwdata[47:0];
          phong_pkg::REG_MAT_AMB:   color_regs[1] <= pwdata[47:0];
          phong_pkg::REG_LIGHT_DIF: color_regs[2] <= pwdata[47:0];
          phong_pkg::REG_MAT_DIF:   color_regs[3] <= pwdata[47:0];
          phong_pkg::REG_LIGHT_SPC: color_regs[4] <= pwdata[47:0];
          phong_pkg::REG_MAT_SPC:   color_regs[5] <= pwdata[47:0];
          default: ;
        endcase
      end
      if (start && !busy)
        color_fifo.push_back(shade(point_x, point_y, point_z, normal_x, normal_y, normal_z));
      if (done) begin
        if (color_fifo.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected color transaction r=%0d g=%0d b=%0d", red, green, blue);
          fail_count <= fail_count + 1;
        end else begin
          want = color_fifo.pop_front();
          if (want.r !== red || want.g !== green || want.b !== blue) begin
            if (fail_count < 10)
              $display("color mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                       want.r, want.g, want.b, red, green, blue);
            fail_count <= fail_count + 1;
          end
        end
      end
      colors_pending <= color_fifo.size();
    end
  end

endmodule

FILE: tb/sv/tb_phong_pixel_shader.sv
// ----------------------------------------------------------------------------
// tb_phong_pixel_shader
// Drives fragments and register writes into the Phong pixel shader over
// several lighting setups, with random gaps, and reports the checker verdict.
// ----------------------------------------------------------------------------
module tb_phong_pixel_shader;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [15:0] point_x, point_y, point_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic               done;
  logic [7:0]         red, green, blue;
  logic               psel, penable, pwrite;
  logic [phong_pkg::ADDR_W-1:0] paddr;
  logic [phong_pkg::DATA_W-1:0] pwdata;
  logic [phong_pkg::DATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 colors_pending;
  int                 cycles = 0;
  bit                 no_gaps;

  phong_pixel_shader dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .done(done), .red(red), .green(green), .blue(blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  phong_shade_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .done(done), .red(red), .green(green), .blue(blue),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .colors_pending(colors_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stop fragments, wait for all colors to drain, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    while (colors_pending != 0) @(posedge clk);
    repeat (phong_pkg::TOP_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(phong_pkg::reg_idx_t idx, logic [47:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= phong_pkg::ADDR_W'(idx) << 3;
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setup(logic [47:0] lpos, logic [15:0] cam, logic [47:0] la,
                            logic [47:0] ma, logic [47:0] ld, logic [47:0] md,
                            logic [47:0] ls, logic [47:0] ms);
    write_reg(phong_pkg::REG_LIGHT_POS, lpos);
    write_reg(phong_pkg::REG_CAM_DIST, {32'h0, cam});
    write_reg(phong_pkg::REG_LIGHT_AMB, la);
    write_reg(phong_pkg::REG_MAT_AMB, ma);
    write_reg(phong_pkg::REG_LIGHT_DIF, ld);
    write_reg(phong_pkg::REG_MAT_DIF, md);
    write_reg(phong_pkg::REG_LIGHT_SPC, ls);
    write_reg(phong_pkg::REG_MAT_SPC, ms);
    @(posedge clk);
  endtask

  // Present one fragment, hold until accepted, then idle for a random gap, which may be zero
  task automatic send_fragment(logic [15:0] px, logic [15:0] py, logic [15:0] pz,
                               logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    int r;
    int gap;
    start    <= 1'b1;
    point_x  <= px;
    point_y  <= py;
    point_z  <= pz;
    normal_x <= nx;
    normal_y <= ny;
    normal_z <= nz;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_normal();
    if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 32768) - 16384);
    return 16'($urandom);
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  initial begin
    logic [47:0] lpos;
    logic [15:0] cam;
    rst      <= 1'b1;
    start    <= 1'b0;
    point_x  <= '0; point_y <= '0; point_z <= '0;
    normal_x <= '0; normal_y <= '0; normal_z <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    no_gaps  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: light at z=-10, camera at z=-5, colors from half to full strength
    lpos = {16'hF600, 16'h0000, 16'h0000};
    load_setup(lpos, 16'h0500, {3{16'h4000}}, {3{16'h6000}}, {3{16'h7000}},
               {3{16'h5000}}, {3{16'h7FFF}}, {3{16'h8000}});
    send_fragment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hC000);
    send_fragment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
    send_fragment(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h4000, 16'h0000, 16'h0000);
    send_fragment(16'h8000, 16'h8000, 16'h8000, 16'hC000, 16'hC000, 16'hC000);
    send_fragment(16'h7FFF, 16'h8000, 16'h0100, 16'h2D41, 16'hD2BF, 16'h0000);
    // light at the point: zero light vector
    send_fragment(16'h0000, 16'h0000, 16'hF600, 16'h0000, 16'h0000, 16'hC000);
    // camera at the point: zero view vector
    send_fragment(16'h0000, 16'h0000, 16'hFB00, 16'h0000, 16'h0000, 16'hC000);
    // normals beyond unit length
    send_fragment(16'h0100, 16'h0200, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_fragment(16'h0100, 16'hFE00, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    send_fragment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_fragment(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF);
    send_fragment(16'h0080, 16'hFF80, 16'h0100, 16'h0000, 16'h4000, 16'h0000);
    drain();

    // Maximum everything: saturation on all channels
    load_setup(48'hFFFF_FFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
               48'hFFFF_FFFF_FFFF);
    send_fragment(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hC000);
    send_fragment(16'h7FFF, 16'h8000, 16'h0000, 16'h4000, 16'h4000, 16'h4000);
    send_fragment(16'h1234, 16'h8765, 16'h7ABC, 16'hC000, 16'h0000, 16'h0000);
    drain();

    // Random phases across several register setups
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_setup('0, '0, '0, '0, '0, '0, '0, '0);
        1: load_setup(48'hFFFF_FFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
                      48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                      48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        2, 3: load_setup(rand48(), 16'($urandom), rand48(), rand48(), rand48(),
                         rand48(), rand48(), rand48());
        default: load_setup({16'($urandom_range(0, 4095) - 2048),
                             16'($urandom_range(0, 4095) - 2048),
                             16'($urandom_range(0, 4095) - 2048)},
                            16'($urandom_range(0, 4095)),
                            {3{16'($urandom_range(0, 32768))}},
                            {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                             16'($urandom_range(0, 32768))},
                            {3{16'($urandom_range(0, 32768))}},
                            {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                             16'($urandom_range(0, 32768))},
                            {3{16'($urandom_range(0, 32768))}},
                            {16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)),
                             16'($urandom_range(0, 32768))});
      endcase
      lpos = u_checker.light_pos;
      cam  = u_checker.cam_dist;
      no_gaps = (ph % 3 == 2);
      for (int i = 0; i < 210; i++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
          send_fragment(lpos[15:0], lpos[31:16], lpos[47:32],
                        rand_normal(), rand_normal(), rand_normal());
        else if (pick < 7)
          send_fragment(16'h0000, 16'h0000, 16'(-cam),
                        rand_normal(), rand_normal(), rand_normal());
        else if (pick < 60)
          send_fragment(16'($urandom_range(0, 8191) - 4096),
                        16'($urandom_range(0, 8191) - 4096),
                        16'($urandom_range(0, 8191) - 4096),
                        rand_normal(), rand_normal(), rand_normal());
        else
          send_fragment(16'($urandom), 16'($urandom), 16'($urandom),
                        rand_normal(), rand_normal(), rand_normal());
      end
      no_gaps = 1'b0;
      drain();
    end

    if (fail_count == 0 && colors_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
